[rtl/core/assert_macros.svh]
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ADCSD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ADCSD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/adcsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcsd_pkg
// shared constants, types and the exp cost table of the stereo disparity core
// ----------------------------------------------------------------------------
package adcsd_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int DISP_RANGE  = 40;
    localparam int WIN_W       = 9;
    localparam int WIN_H       = 7;
    localparam int RWIN_W      = DISP_RANGE + 8;
    localparam int CEN_R       = WIN_H / 2;
    localparam int CEN_C       = WIN_W / 2;
    localparam int PIX_W       = 24;
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int LINE_ROWS   = 6;
    localparam int SLOT_W      = 3;
    localparam int LINE_WORD_W = LINE_ROWS * 2 * PIX_W;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 10;
    localparam int CFG_W       = 11;
    localparam int DISP_W      = 6;
    localparam int STEP_W      = $clog2(RWIN_W);
    localparam int TERM_W      = 17;
    localparam int COST_W      = 18;
    localparam int ROM_SIZE    = 766;
    localparam int ROM_IDX_W   = 10;
    localparam int SAD_W       = 10;
    localparam int CEN_CH_W    = 6;
    localparam int CEN_W       = 8;
    localparam int ADDR_W      = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [CFG_W-1:0] MIN_WIDTH_V    = CFG_W'(16);
    localparam logic [CFG_W-1:0] MAX_WIDTH_V    = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] MIN_HEIGHT_V   = CFG_W'(8);
    localparam logic [CFG_W-1:0] MAX_HEIGHT_V   = CFG_W'(1024);
    localparam logic [CFG_W-1:0] RESET_WIDTH_V  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RESET_HEIGHT_V = CFG_W'(480);
    localparam logic [COL_W-1:0] FIRST_X        = COL_W'(8);
    localparam logic [ROW_W-1:0] FIRST_Y        = ROW_W'(6);
    localparam logic [COL_W-1:0] CTR_X_OFF      = COL_W'(4);
    localparam logic [ROW_W-1:0] CTR_Y_OFF      = ROW_W'(3);
    localparam logic [SLOT_W-1:0] LAST_SLOT     = SLOT_W'(LINE_ROWS - 1);
    localparam logic [63:0]      EXP_STEP       = 64'd4154161520;
    localparam logic [TERM_W-1:0] TERM_ONE      = TERM_W'(65536);

    typedef enum logic {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCORE,
        ST_DONE
    } t_state;

    typedef logic [PIX_W-1:0]                         t_pix;
    typedef logic [WIN_H-1:0][PIX_W-1:0]              t_col;
    typedef logic [WIN_H-1:0][WIN_W-1:0][PIX_W-1:0]   t_win;
    typedef logic [ROM_SIZE-1:0][TERM_W-1:0]          t_cost_rom;

    typedef struct packed {
        logic shift;
        logic rotate;
    } t_win_ctrl;

    // 1 - exp(-n/30) in q0.16, built by repeated fixed-point scaling
    function automatic t_cost_rom build_cost_rom();
        logic [63:0] e;
        t_cost_rom   rom;
        e = 64'd1 << 32;
        for (int n = 0; n < ROM_SIZE; n++) begin
            rom[n] = TERM_ONE - TERM_W'((e + 64'd32768) >> 16);
            e = (e * EXP_STEP + (64'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

    localparam t_cost_rom COST_ROM = build_cost_rom();

endpackage

[rtl/core/adcsd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcsd_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module adcsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/adcsd_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcsd_window
// six-row line store with read-modify-write, left and right window registers
// ----------------------------------------------------------------------------
module adcsd_window import adcsd_pkg::*; (
    input  logic               i_clk,
    input  t_win_ctrl          i_ctrl,
    input  logic               i_rd_en,
    input  logic [COL_W-1:0]   i_rd_addr,
    input  logic [COL_W-1:0]   i_wr_addr,
    input  logic [SLOT_W-1:0]  i_slot,
    input  t_pix               i_lpix,
    input  t_pix               i_rpix,
    output t_win               o_lwin,
    output t_win               o_rview
);

    logic [LINE_WORD_W-1:0] w_rdata;
    logic [LINE_WORD_W-1:0] w_wdata;
    t_col                   w_lcol;
    t_col                   w_rcol;
    logic [SLOT_W:0]        w_idx [LINE_ROWS];

    t_win                                   r_lwin;
    logic [WIN_H-1:0][RWIN_W-1:0][PIX_W-1:0] r_rwin;

    adcsd_ram #(
        .WIDTH (LINE_WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.shift),
        .i_waddr (i_wr_addr),
        .i_wdata (w_wdata),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rdata)
    );

    // oldest row first: slot (y + k) mod 6
    always_comb begin
        for (int k = 0; k < LINE_ROWS; k++) begin
            w_idx[k] = {1'b0, i_slot} + (SLOT_W + 1)'(k);
            if (w_idx[k] >= (SLOT_W + 1)'(LINE_ROWS)) begin
                w_idx[k] = w_idx[k] - (SLOT_W + 1)'(LINE_ROWS);
            end
        end
        w_lcol = '0;
        w_rcol = '0;
        for (int k = 0; k < LINE_ROWS; k++) begin
            for (int s = 0; s < LINE_ROWS; s++) begin
                if (w_idx[k] == (SLOT_W + 1)'(s)) begin
                    w_lcol[k] = w_rdata[s*2*PIX_W +: PIX_W];
                    w_rcol[k] = w_rdata[s*2*PIX_W + PIX_W +: PIX_W];
                end
            end
        end
        w_lcol[WIN_H-1] = i_lpix;
        w_rcol[WIN_H-1] = i_rpix;
        w_wdata = w_rdata;
        for (int s = 0; s < LINE_ROWS; s++) begin
            if (i_slot == SLOT_W'(s)) begin
                w_wdata[s*2*PIX_W +: 2*PIX_W] = {i_rpix, i_lpix};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            for (int k = 0; k < WIN_H; k++) begin
                for (int c = 0; c < WIN_W - 1; c++) begin
                    r_lwin[k][c] <= r_lwin[k][c+1];
                end
                r_lwin[k][WIN_W-1] <= w_lcol[k];
                for (int c = 0; c < RWIN_W - 1; c++) begin
                    r_rwin[k][c] <= r_rwin[k][c+1];
                end
                r_rwin[k][RWIN_W-1] <= w_rcol[k];
            end
        end else if (i_ctrl.rotate) begin
            // circular shift right, one disparity per step, full turn restores
            for (int k = 0; k < WIN_H; k++) begin
                for (int c = 1; c < RWIN_W; c++) begin
                    r_rwin[k][c] <= r_rwin[k][c-1];
                end
                r_rwin[k][0] <= r_rwin[k][RWIN_W-1];
            end
        end
    end

    always_comb begin
        o_lwin = r_lwin;
        for (int k = 0; k < WIN_H; k++) begin
            for (int j = 0; j < WIN_W; j++) begin
                o_rview[k][j] = r_rwin[k][RWIN_W-WIN_W+j];
            end
        end
    end

endmodule

[rtl/core/adcsd_cost.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcsd_cost
// three-stage pipeline: census compares and ad, bit counts, exp table and sum
// ----------------------------------------------------------------------------
module adcsd_cost import adcsd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [DISP_W-1:0]  i_disp,
    input  t_win               i_lwin,
    input  t_win               i_rwin,
    output logic               o_valid,
    output logic [DISP_W-1:0]  o_disp,
    output logic [COST_W-1:0]  o_cost
);

    logic [NUM_CHAN-1:0][WIN_H*WIN_W-1:0] w_cmp;
    logic [SAD_W-1:0]                     w_sad;
    logic [CHAN_W-1:0]                    w_lc, w_rc, w_lv, w_rv, w_ad;
    logic [CEN_W-1:0]                     w_cen;

    logic [NUM_CHAN-1:0][WIN_H*WIN_W-1:0] r_cmp;
    logic [SAD_W-1:0]                     r_sad_a, r_sad_b;
    logic [NUM_CHAN-1:0][CEN_CH_W-1:0]    r_cnt;
    logic                                 r_vld_a, r_vld_b, r_vld_c;
    logic [DISP_W-1:0]                    r_disp_a, r_disp_b, r_disp_c;
    logic [COST_W-1:0]                    r_cost;

    always_comb begin
        w_sad = '0;
        w_cmp = '0;
        w_lv  = '0;
        w_rv  = '0;
        w_lc  = '0;
        w_rc  = '0;
        w_ad  = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            w_lc = i_lwin[CEN_R][CEN_C][c*CHAN_W +: CHAN_W];
            w_rc = i_rwin[CEN_R][CEN_C][c*CHAN_W +: CHAN_W];
            w_ad = (w_lc > w_rc) ? (w_lc - w_rc) : (w_rc - w_lc);
            w_sad = w_sad + SAD_W'(w_ad);
            for (int r = 0; r < WIN_H; r++) begin
                for (int j = 0; j < WIN_W; j++) begin
                    w_lv = i_lwin[r][j][c*CHAN_W +: CHAN_W];
                    w_rv = i_rwin[r][j][c*CHAN_W +: CHAN_W];
                    if (!(r == CEN_R && j == CEN_C)) begin
                        w_cmp[c][r*WIN_W+j] = ((w_lv < w_lc) && (w_rv > w_rc)) ||
                                              ((w_lv > w_lc) && (w_rv < w_rc));
                    end
                end
            end
        end
        w_cen = CEN_W'(r_cnt[0]) + CEN_W'(r_cnt[1]) + CEN_W'(r_cnt[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
        end
        r_cmp    <= w_cmp;
        r_sad_a  <= w_sad;
        r_disp_a <= i_disp;
        for (int c = 0; c < NUM_CHAN; c++) begin
            r_cnt[c] <= CEN_CH_W'($countones(r_cmp[c]));
        end
        r_sad_b  <= r_sad_a;
        r_disp_b <= r_disp_a;
        r_cost   <= {1'b0, COST_ROM[r_sad_b]} +
                    {1'b0, COST_ROM[ROM_IDX_W'(w_cen)]};
        r_disp_c <= r_disp_b;
    end

    assign o_valid = r_vld_c;
    assign o_disp  = r_disp_c;
    assign o_cost  = r_cost;

endmodule

[rtl/core/ad_census_stereo_disparity_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ad_census_stereo_disparity_core
// ad-census disparity search over a 9x7 window, up to forty disparities per centre
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  pixels    in         i_valid / o_stall   start_of_frame, left and right rgb
//  result    out        o_valid / i_stall   disparity, centre x/y, best cost
//  config    in         apb (psel..pready)  image_width @0x0, image_height @0x4
//
// a request without a full window passes through accept and read-modify-write of the line store;
// a scored request passes through accept, read-modify-write of the line store,
// 48 steps of the right window rotation feeding the cost pipeline, then retire.
// the line store ram has no clearing pass; reset clears counters and control only.
// a finished result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ad_census_stereo_disparity_core import adcsd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_start_of_frame,
    input  logic [CHAN_W-1:0]      i_left_red,
    input  logic [CHAN_W-1:0]      i_left_green,
    input  logic [CHAN_W-1:0]      i_left_blue,
    input  logic [CHAN_W-1:0]      i_right_red,
    input  logic [CHAN_W-1:0]      i_right_green,
    input  logic [CHAN_W-1:0]      i_right_blue,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [DISP_W-1:0]      o_disparity,
    output logic [COL_W-1:0]       o_center_x,
    output logic [ROW_W-1:0]       o_center_y,
    output logic [COST_W-1:0]      o_best_cost,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_width_cfg, r_height_cfg;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [SLOT_W-1:0]   r_slot;
    logic [COL_W-1:0]    r_x;
    logic [ROW_W-1:0]    r_y;
    logic [SLOT_W-1:0]   r_cur_slot;
    t_pix                r_lpix, r_rpix;
    logic                r_score;
    logic [STEP_W-1:0]   r_step;
    logic [COST_W-1:0]   r_best_cost;
    logic [DISP_W-1:0]   r_best_disp;
    logic                r_out_valid;
    logic [DISP_W-1:0]   r_out_disp;
    logic [COL_W-1:0]    r_out_x;
    logic [ROW_W-1:0]    r_out_y;
    logic [COST_W-1:0]   r_out_cost;

    logic                w_acc, w_cfg_wr, w_out_load, w_cost_in;
    t_win_ctrl           w_ctrl;
    t_reg_idx            w_reg;
    logic [CFG_W-1:0]    w_w, w_h;
    logic [CFG_W-1:0]    w_c0, w_r0, w_cn, w_rn;
    logic [SLOT_W-1:0]   w_s0, w_sn;
    logic [COL_W-1:0]    w_x, w_col_n;
    logic [ROW_W-1:0]    w_y, w_row_n;
    t_win                w_lwin, w_rview;
    logic                w_cost_vld;
    logic [DISP_W-1:0]   w_cost_disp;
    logic [COST_W-1:0]   w_cost;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (w_reg)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_width_cfg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_height_cfg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= RESET_WIDTH_V;
            r_height_cfg <= RESET_HEIGHT_V;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_IMAGE_WIDTH:  r_width_cfg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: r_height_cfg <= pwdata[CFG_W-1:0];
                default:          r_width_cfg  <= r_width_cfg;
            endcase
        end
    end

    // raster position of the arriving pixel and of the one after it
    always_comb begin
        w_w = (r_width_cfg < MIN_WIDTH_V) ? MIN_WIDTH_V :
              ((r_width_cfg > MAX_WIDTH_V) ? MAX_WIDTH_V : r_width_cfg);
        w_h = (r_height_cfg < MIN_HEIGHT_V) ? MIN_HEIGHT_V :
              ((r_height_cfg > MAX_HEIGHT_V) ? MAX_HEIGHT_V : r_height_cfg);

        w_c0 = i_start_of_frame ? '0 : CFG_W'(r_col);
        w_r0 = i_start_of_frame ? '0 : CFG_W'(r_row);
        w_s0 = i_start_of_frame ? '0 : r_slot;
        if (w_c0 >= w_w) begin
            w_c0 = '0;
            w_r0 = w_r0 + CFG_W'(1);
            w_s0 = (w_s0 == LAST_SLOT) ? '0 : w_s0 + SLOT_W'(1);
        end
        if (w_r0 >= w_h) begin
            w_r0 = '0;
            w_s0 = '0;
        end
        w_x = w_c0[COL_W-1:0];
        w_y = w_r0[ROW_W-1:0];

        w_cn = CFG_W'(w_x) + CFG_W'(1);
        w_rn = CFG_W'(w_y);
        w_sn = w_s0;
        if (w_cn >= w_w) begin
            w_cn = '0;
            w_rn = CFG_W'(w_y) + CFG_W'(1);
            w_sn = (w_s0 == LAST_SLOT) ? '0 : w_s0 + SLOT_W'(1);
            if (w_rn >= w_h) begin
                w_rn = '0;
                w_sn = '0;
            end
        end
        w_col_n = w_cn[COL_W-1:0];
        w_row_n = w_rn[ROW_W-1:0];
    end

    // control
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_acc) n_state = ST_LOAD;
            ST_LOAD:  n_state = r_score ? ST_SCORE : ST_IDLE;
            ST_SCORE: if (r_step == STEP_W'(RWIN_W - 1)) n_state = ST_DONE;
            ST_DONE:  if (!r_out_valid || !i_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall       = (r_state != ST_IDLE);
        w_acc         = i_valid && (r_state == ST_IDLE);
        w_ctrl.shift  = (r_state == ST_LOAD);
        w_ctrl.rotate = (r_state == ST_SCORE);
        w_cost_in     = (r_state == ST_SCORE) && (r_step < STEP_W'(DISP_RANGE)) &&
                        (COL_W'(r_step) <= (r_x - FIRST_X));
        w_out_load    = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_best_cost <= '1;
            r_best_disp <= '0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                r_col  <= w_col_n;
                r_row  <= w_row_n;
                r_slot <= w_sn;
            end
            if (r_state == ST_LOAD) begin
                r_step      <= '0;
                r_best_cost <= '1;
                r_best_disp <= '0;
            end else begin
                if (r_state == ST_SCORE) begin
                    r_step <= r_step + STEP_W'(1);
                end
                if (w_cost_vld && (w_cost < r_best_cost)) begin
                    r_best_cost <= w_cost;
                    r_best_disp <= w_cost_disp;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_x        <= w_x;
            r_y        <= w_y;
            r_cur_slot <= w_s0;
            r_lpix     <= {i_left_blue, i_left_green, i_left_red};
            r_rpix     <= {i_right_blue, i_right_green, i_right_red};
            r_score    <= (w_x >= FIRST_X) && (w_y >= FIRST_Y);
        end
        if (w_out_load) begin
            r_out_disp <= r_best_disp;
            r_out_x    <= r_x - CTR_X_OFF;
            r_out_y    <= r_y - CTR_Y_OFF;
            r_out_cost <= r_best_cost;
        end
    end

    adcsd_window u_window (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl),
        .i_rd_en   (w_acc),
        .i_rd_addr (w_x),
        .i_wr_addr (r_x),
        .i_slot    (r_cur_slot),
        .i_lpix    (r_lpix),
        .i_rpix    (r_rpix),
        .o_lwin    (w_lwin),
        .o_rview   (w_rview)
    );

    adcsd_cost u_cost (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cost_in),
        .i_disp  (DISP_W'(r_step)),
        .i_lwin  (w_lwin),
        .i_rwin  (w_rview),
        .o_valid (w_cost_vld),
        .o_disp  (w_cost_disp),
        .o_cost  (w_cost)
    );

    assign o_valid     = r_out_valid;
    assign o_disparity = r_out_disp;
    assign o_center_x  = r_out_x;
    assign o_center_y  = r_out_y;
    assign o_best_cost = r_out_cost;

    `ADCSD_ASSERT_IMP(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), ($past(r_state) == ST_DONE), "result loaded outside the retire state")
    `ADCSD_ASSERT_NXT(a_score_init, i_clk, i_rst_n, (r_state == ST_LOAD && r_score), (r_step == '0 && r_best_cost == '1), "disparity search not restarted")
    `ADCSD_ASSERT_IMP(a_disp_range, i_clk, i_rst_n, o_valid, ((o_disparity < DISP_W'(DISP_RANGE)) && (COL_W'(o_disparity) <= (o_center_x - CTR_X_OFF))), "winning disparity leaves the image")

endmodule
